@@ rtl/cbf_pkg.sv @@
// shared types and constants for the cubic bezier flattener
`timescale 1ns / 1ps
package cbf_pkg;

    localparam int IN_W       = 16;
    localparam int COORD_W    = 35;
    localparam int FRAC_SHIFT = 18;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MB_W       = 19;
    localparam int MPROD_W    = DIFF_W + MB_W;
    localparam int PROD_W     = 73;
    localparam int SUM_W      = 75;
    localparam int THR_W      = 32;
    localparam int LIM_SHIFT  = 36;
    localparam int LEVEL_W    = 3;
    localparam int NUM_PTS    = 8;
    localparam int STEP_W     = 4;
    localparam int CNT_W      = 5;
    localparam int MUL_STEPS  = 16;
    localparam int EVAL_LAST  = 17;

    localparam logic [THR_W-1:0] THR_RESET = 32'd1024;
    localparam int MAX_DEPTH_DEF = 6;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              load_in;
        logic              clear_sum;
        logic              mul_en;
        logic [STEP_W-1:0] mul_step;
        logic              emit;
        logic              split;
        logic              pop;
        logic              load_pop;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic flat;
        logic at_limit;
        logic top_zero;
    } status_t;

endpackage

@@ rtl/cbf_ctrl.sv @@
// controller sequencing flatness test, emit, split and pop
`timescale 1ns / 1ps
module cbf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cbf_pkg::status_t status,
    output cbf_pkg::cmd_t    cmd
);
    import cbf_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state and cycle counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_step = cnt_reg[STEP_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.clear_sum = (cnt_reg == '0);
                cmd.mul_en    = (cnt_reg < CNT_W'(MUL_STEPS));
                if (cnt_reg == CNT_W'(EVAL_LAST))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
                if (status.flat || status.at_limit)
                begin
                    cmd.emit = 1'b1;
                    if (status.top_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    cmd.split  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_LOAD:
            begin
                cmd.load_pop = 1'b1;
                cnt_next     = '0;
                state_next   = ST_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cbf_datapath.sv @@
// datapath: current piece, cross product multiplier, flatness sum, pending stack
`timescale 1ns / 1ps
module cbf_datapath #(
    parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cbf_pkg::THR_W-1:0]        cfg_data,
    input  logic signed [cbf_pkg::IN_W-1:0]  start_x,
    input  logic signed [cbf_pkg::IN_W-1:0]  start_y,
    input  logic signed [cbf_pkg::IN_W-1:0]  ctrl1_x,
    input  logic signed [cbf_pkg::IN_W-1:0]  ctrl1_y,
    input  logic signed [cbf_pkg::IN_W-1:0]  ctrl2_x,
    input  logic signed [cbf_pkg::IN_W-1:0]  ctrl2_y,
    input  logic signed [cbf_pkg::IN_W-1:0]  end_x,
    input  logic signed [cbf_pkg::IN_W-1:0]  end_y,
    input  cbf_pkg::cmd_t                    cmd,
    output cbf_pkg::status_t                 status,
    output logic                             piece_valid,
    output cbf_pkg::coord_t                  piece_pts [cbf_pkg::NUM_PTS],
    output logic                             forced_flat,
    output logic                             last_piece
);
    import cbf_pkg::*;

    localparam int TOP_W  = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ROW_W  = NUM_PTS * COORD_W + LEVEL_W;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic [ROW_W-1:0]         row_t;

    function automatic coord_t half_sum(input coord_t a, input coord_t b);
        diff_t s;
        diff_t t;
        begin
            s = DIFF_W'(a) + DIFF_W'(b);
            // halve toward zero: negative sums get one added before the shift
            t = s + DIFF_W'(s[DIFF_W-1]);
            half_sum = t[DIFF_W-1:1];
        end
    endfunction

    logic [THR_W-1:0]       thr_reg;
    coord_t                 cur_reg [NUM_PTS];
    logic [LEVEL_W-1:0]     level_reg;
    logic [TOP_W-1:0]       top_reg;
    row_t                   mem [MAX_DEPTH];
    row_t                   rd_reg;
    logic signed [PROD_W-1:0] pp_reg;
    logic [STEP_W-1:0]      pp_step_reg;
    logic                   pp_valid_reg;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic                   cross_done_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   valid_reg;
    coord_t                 out_reg [NUM_PTS];
    logic                   forced_reg;
    logic                   last_reg;

    diff_t vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3, vx4, vy4;
    diff_t a_op, b_op;
    logic signed [MB_W-1:0]    mb;
    logic signed [MPROD_W-1:0] prod;
    logic signed [PROD_W-1:0]  prod_ext, pp_next, acc_base;
    logic [PROD_W-1:0]         acc_abs;
    logic [SUM_W-1:0]          lim;
    logic                      flat;
    coord_t                    first [NUM_PTS];
    coord_t                    second [NUM_PTS];
    coord_t                    in_pts [NUM_PTS];
    row_t                      wr_row;

    // difference vectors of the current piece
    always_comb
    begin
        vx0 = DIFF_W'(cur_reg[2]) - DIFF_W'(cur_reg[0]);
        vy0 = DIFF_W'(cur_reg[3]) - DIFF_W'(cur_reg[1]);
        vx1 = DIFF_W'(cur_reg[4]) - DIFF_W'(cur_reg[2]);
        vy1 = DIFF_W'(cur_reg[5]) - DIFF_W'(cur_reg[3]);
        vx2 = DIFF_W'(cur_reg[6]) - DIFF_W'(cur_reg[4]);
        vy2 = DIFF_W'(cur_reg[7]) - DIFF_W'(cur_reg[5]);
        vx3 = DIFF_W'(cur_reg[4]) - DIFF_W'(cur_reg[0]);
        vy3 = DIFF_W'(cur_reg[5]) - DIFF_W'(cur_reg[1]);
        vx4 = DIFF_W'(cur_reg[6]) - DIFF_W'(cur_reg[0]);
        vy4 = DIFF_W'(cur_reg[7]) - DIFF_W'(cur_reg[1]);
    end

    // operand select: even products add, odd products subtract
    always_comb
    begin
        unique case (cmd.mul_step[STEP_W-1:1])
            3'd0: begin a_op = vx0; b_op = vy1; end
            3'd1: begin a_op = vy0; b_op = vx1; end
            3'd2: begin a_op = vx1; b_op = vy2; end
            3'd3: begin a_op = vy1; b_op = vx2; end
            3'd4: begin a_op = vx3; b_op = vy4; end
            3'd5: begin a_op = vy3; b_op = vx4; end
            3'd6: begin a_op = vx0; b_op = vy4; end
            3'd7: begin a_op = vy0; b_op = vx4; end
            default: begin a_op = vx0; b_op = vy1; end
        endcase
    end

    // one 36x19 partial product per cycle, low half then high half
    always_comb
    begin
        if (cmd.mul_step[0])
        begin
            mb = {b_op[DIFF_W-1], b_op[DIFF_W-1:FRAC_SHIFT]};
        end
        else
        begin
            mb = {1'b0, b_op[FRAC_SHIFT-1:0]};
        end
        prod     = MPROD_W'(a_op) * MPROD_W'(mb);
        prod_ext = PROD_W'(prod);
        pp_next  = cmd.mul_step[0] ? (prod_ext <<< FRAC_SHIFT) : prod_ext;
    end

    // cross product accumulation and flatness compare
    always_comb
    begin
        acc_base = (pp_step_reg[1:0] == 2'd0) ? '0 : acc_reg;
        acc_next = pp_step_reg[1] ? (acc_base - pp_reg) : (acc_base + pp_reg);
        acc_abs  = acc_reg[PROD_W-1] ? PROD_W'(-acc_reg) : PROD_W'(acc_reg);
        lim      = SUM_W'(thr_reg) << LIM_SHIFT;
        flat     = (sum_reg < lim);
    end

    // de casteljau split at the midpoint, x and y alike
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            coord_t m, a, d, b, e, c;
            m = half_sum(cur_reg[2 + k], cur_reg[4 + k]);
            a = half_sum(cur_reg[k], cur_reg[2 + k]);
            d = half_sum(cur_reg[4 + k], cur_reg[6 + k]);
            b = half_sum(a, m);
            e = half_sum(m, d);
            c = half_sum(b, e);
            first[k]      = cur_reg[k];
            first[2 + k]  = a;
            first[4 + k]  = b;
            first[6 + k]  = c;
            second[k]     = c;
            second[2 + k] = e;
            second[4 + k] = d;
            second[6 + k] = cur_reg[6 + k];
        end
        wr_row[LEVEL_W-1:0] = level_reg + 1'b1;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            wr_row[LEVEL_W + i*COORD_W +: COORD_W] = second[i];
        end
    end

    // input widening to the internal format
    always_comb
    begin
        in_pts[0] = COORD_W'(start_x) <<< FRAC_SHIFT;
        in_pts[1] = COORD_W'(start_y) <<< FRAC_SHIFT;
        in_pts[2] = COORD_W'(ctrl1_x) <<< FRAC_SHIFT;
        in_pts[3] = COORD_W'(ctrl1_y) <<< FRAC_SHIFT;
        in_pts[4] = COORD_W'(ctrl2_x) <<< FRAC_SHIFT;
        in_pts[5] = COORD_W'(ctrl2_y) <<< FRAC_SHIFT;
        in_pts[6] = COORD_W'(end_x) <<< FRAC_SHIFT;
        in_pts[7] = COORD_W'(end_y) <<< FRAC_SHIFT;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            top_reg        <= '0;
            pp_valid_reg   <= 1'b0;
            cross_done_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.load_in)
            begin
                top_reg <= '0;
            end
            else if (cmd.split)
            begin
                top_reg <= top_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                top_reg <= top_reg - 1'b1;
            end
            pp_valid_reg   <= cmd.mul_en;
            cross_done_reg <= pp_valid_reg && (pp_step_reg[1:0] == 2'd3);
            valid_reg      <= cmd.emit;
        end
    end

    // piece registers, multiplier pipeline and result beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_reg   <= in_pts;
            level_reg <= '0;
        end
        else if (cmd.split)
        begin
            cur_reg   <= first;
            level_reg <= level_reg + 1'b1;
        end
        else if (cmd.load_pop)
        begin
            level_reg <= rd_reg[LEVEL_W-1:0];
            for (int i = 0; i < NUM_PTS; i++)
            begin
                cur_reg[i] <= rd_reg[LEVEL_W + i*COORD_W +: COORD_W];
            end
        end
        pp_reg      <= pp_next;
        pp_step_reg <= cmd.mul_step;
        if (pp_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.clear_sum)
        begin
            sum_reg <= '0;
        end
        else if (cross_done_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(acc_abs);
        end
        if (cmd.emit)
        begin
            out_reg    <= cur_reg;
            forced_reg <= !flat;
            last_reg   <= (top_reg == '0);
        end
    end

    // pending stack of second halves
    always_ff @(posedge clk)
    begin
        if (cmd.split)
        begin
            mem[top_reg[ADDR_W-1:0]] <= wr_row;
        end
        if (cmd.pop)
        begin
            rd_reg <= mem[ADDR_W'(top_reg - 1'b1)];
        end
    end

    assign status.flat     = flat;
    assign status.at_limit = (level_reg >= LEVEL_W'(MAX_DEPTH));
    assign status.top_zero = (top_reg == '0);
    assign piece_valid     = valid_reg;
    assign piece_pts       = out_reg;
    assign forced_flat     = forced_reg;
    assign last_piece      = last_reg;

endmodule

@@ rtl/cubic_bezier_adaptive_flattener.sv @@
// top level of the adaptive cubic bezier flattener
`timescale 1ns / 1ps
// Usage:
// A segment (four Q12.4 points) is taken at a clock edge where start is high
// and busy is low. The block then emits its flat pieces in Q13.22, first half
// before second, each for one cycle with piece_valid high; last_piece marks
// the final piece of the segment and forced_flat a piece cut at the depth
// limit. The receiver cannot stall: every piece must be taken when shown.
// Each piece is tested by one 36x19 multiplier that forms the four cross
// products in sixteen partial products. After a split the first half is
// tested; after a piece other than the last is emitted, the next one is
// popped from the pending stack and loaded before its test. A fully split
// segment gives 2^MAX_DEPTH pieces. busy drops in the cycle the last piece
// is shown. cfg_we writes flatness_threshold; the user must write it only
// while idle, the block itself does not enforce this. Reset returns the
// block to idle with threshold 1024 and an empty stack.
module cubic_bezier_adaptive_flattener #(
    parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cbf_pkg::THR_W-1:0]           cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cbf_pkg::IN_W-1:0]     start_x,
    input  logic signed [cbf_pkg::IN_W-1:0]     start_y,
    input  logic signed [cbf_pkg::IN_W-1:0]     ctrl1_x,
    input  logic signed [cbf_pkg::IN_W-1:0]     ctrl1_y,
    input  logic signed [cbf_pkg::IN_W-1:0]     ctrl2_x,
    input  logic signed [cbf_pkg::IN_W-1:0]     ctrl2_y,
    input  logic signed [cbf_pkg::IN_W-1:0]     end_x,
    input  logic signed [cbf_pkg::IN_W-1:0]     end_y,
    output logic                                piece_valid,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_start_x,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_start_y,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_c1_x,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_c1_y,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_c2_x,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_c2_y,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_end_x,
    output logic signed [cbf_pkg::COORD_W-1:0]  piece_end_y,
    output logic                                forced_flat,
    output logic                                last_piece
);
    import cbf_pkg::*;

    cmd_t    cmd;
    status_t status;
    coord_t  pts [NUM_PTS];

    // sequencer
    cbf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // arithmetic and storage
    cbf_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .ctrl1_x     (ctrl1_x),
        .ctrl1_y     (ctrl1_y),
        .ctrl2_x     (ctrl2_x),
        .ctrl2_y     (ctrl2_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .cmd         (cmd),
        .status      (status),
        .piece_valid (piece_valid),
        .piece_pts   (pts),
        .forced_flat (forced_flat),
        .last_piece  (last_piece)
    );

    assign piece_start_x = pts[0];
    assign piece_start_y = pts[1];
    assign piece_c1_x    = pts[2];
    assign piece_c1_y    = pts[3];
    assign piece_c2_x    = pts[4];
    assign piece_c2_y    = pts[5];
    assign piece_end_x   = pts[6];
    assign piece_end_y   = pts[7];

endmodule
